/* rtl/ils_pkg.sv */
// ils_pkg: shared widths, capacity, request codes and controller/datapath command and
// status types for the indexed list store; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

   localparam int WORD_W   = 32;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;
   localparam int OP_W     = 3;
   localparam int CAPACITY = 64;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_SET    = 3'd2,
      OP_READ   = 3'd3,
      OP_FIND   = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_ZERO,
      IDX_POS,
      IDX_TOP,
      IDX_INC,
      IDX_DEC
   } idx_sel_type;

   typedef enum logic [1:0] {
      RA_IDX,
      RA_IDX_DEC,
      RA_IDX_INC,
      RA_POS
   } rd_sel_type;

   typedef enum logic {
      WA_IDX,
      WA_POS
   } wa_sel_type;

   typedef enum logic [1:0] {
      WD_ZERO,
      WD_VALUE,
      WD_RDATA
   } wd_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_NEW,
      CNT_DEC,
      CNT_ZERO
   } cnt_sel_type;

   typedef struct packed {
      logic        in_ready;
      idx_sel_type idx_sel;
      logic        mem_rd;
      rd_sel_type  rd_sel;
      logic        mem_wr;
      wa_sel_type  wa_sel;
      wd_sel_type  wd_sel;
      cnt_sel_type cnt_sel;
      logic        res_read;
      logic        res_found;
      logic        res_reject;
      logic        out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic            in_valid;
      logic [OP_W-1:0] op;
      logic            pos_lt_count;
      logic            over_cap;
      logic            idx_lt_pos;
      logic            idx_gt_pos;
      logic            idx_lt_count;
      logic            idx_inc_lt_count;
      logic            match;
      logic            out_free;
   } ctl_status_type;

endpackage

`default_nettype wire

/* rtl/ils_if.sv */
// ils_req_if and ils_rsp_if: valid/ready channels for requests and results
// depends on ils_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ils_req_if;
   logic                          valid;
   logic                          ready;
   logic [ils_pkg::OP_W-1:0]      op;
   logic [ils_pkg::WORD_W-1:0]    value;
   logic [ils_pkg::POS_W-1:0]     position;

   modport source (output valid, output op, output value, output position, input ready);
   modport sink (input valid, input op, input value, input position, output ready);
endinterface

interface ils_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ils_pkg::WORD_W-1:0]    read_word;
   logic                          found;
   logic [ils_pkg::POS_W-1:0]     found_position;
   logic [ils_pkg::COUNT_W-1:0]   entry_total;
   logic                          rejected;

   modport source (output valid, output read_word, output found, output found_position,
                   output entry_total, output rejected, input ready);
   modport sink (input valid, input read_word, input found, input found_position,
                 input entry_total, input rejected, output ready);
endinterface

`default_nettype wire

/* rtl/ils_ram.sv */
// ils_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/ils_datapath.sv */
// ils_datapath: request registers, entry count, walk index, list ram and
// result/output registers; depends on ils_pkg, ils_if and ils_ram
`timescale 1ns / 1ps
`default_nettype none

module ils_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   ils_req_if.sink                      req_chan,
   ils_rsp_if.source                    rsp_chan,
   input  wire ils_pkg::ctl_cmd_type    cmd,
   output      ils_pkg::ctl_status_type status
);
   import ils_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam logic [12:0] CAP_LIMIT = 13'(CAPACITY);

   logic [OP_W-1:0]    op_ff;
   logic [WORD_W-1:0]  value_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;

   logic [WORD_W-1:0]  rd_word_ff;
   logic               found_ff;
   logic [POS_W-1:0]   fpos_ff;
   logic               rej_ff;

   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  out_word_ff;
   logic               out_found_ff;
   logic [POS_W-1:0]   out_fpos_ff;
   logic [COUNT_W-1:0] out_total_ff;
   logic               out_rej_ff;

   logic [COUNT_W-1:0] pos_ext;
   logic [COUNT_W-1:0] max_pc;
   logic [COUNT_W-1:0] newc;
   logic [COUNT_W-1:0] rd_full;
   logic [COUNT_W-1:0] wr_full;
   logic [WORD_W-1:0]  wr_data;
   logic [WORD_W-1:0]  rd_data;
   logic               load_req;

   assign load_req = cmd.in_ready && req_chan.valid;
   assign pos_ext  = {1'b0, pos_ff};
   assign max_pc   = (pos_ext > count_ff) ? pos_ext : count_ff;
   assign newc     = (op_ff == OP_SET) ? (pos_ext + 7'd1) : (max_pc + 7'd1);

   always_comb begin
      case (cmd.idx_sel)
         IDX_COUNT: idx_in = count_ff;
         IDX_ZERO:  idx_in = '0;
         IDX_POS:   idx_in = pos_ext;
         IDX_TOP:   idx_in = newc - 7'd1;
         IDX_INC:   idx_in = idx_ff + 7'd1;
         IDX_DEC:   idx_in = idx_ff - 7'd1;
         default:   idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_sel)
         CNT_NEW:  count_in = newc;
         CNT_DEC:  count_in = count_ff - 7'd1;
         CNT_ZERO: count_in = '0;
         default:  count_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         RA_IDX_DEC: rd_full = idx_ff - 7'd1;
         RA_IDX_INC: rd_full = idx_ff + 7'd1;
         RA_POS:     rd_full = pos_ext;
         default:    rd_full = idx_ff;
      endcase
   end

   assign wr_full = (cmd.wa_sel == WA_POS) ? pos_ext : idx_ff;

   always_comb begin
      case (cmd.wd_sel)
         WD_VALUE: wr_data = value_ff;
         WD_RDATA: wr_data = rd_data;
         default:  wr_data = '0;
      endcase
   end

   ils_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.mem_wr),
      .wr_addr (wr_full[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.mem_rd),
      .rd_addr (rd_full[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (load_req) begin
         op_ff      <= req_chan.op;
         value_ff   <= req_chan.value;
         pos_ff     <= req_chan.position;
         rd_word_ff <= '0;
         found_ff   <= 1'b0;
         fpos_ff    <= '0;
         rej_ff     <= 1'b0;
      end else begin
         if (cmd.res_read) begin
            rd_word_ff <= rd_data;
         end
         if (cmd.res_found) begin
            found_ff <= 1'b1;
            fpos_ff  <= idx_ff[POS_W-1:0];
         end
         if (cmd.res_reject) begin
            rej_ff <= 1'b1;
         end
      end
      if (cmd.out_load) begin
         out_word_ff  <= rd_word_ff;
         out_found_ff <= found_ff;
         out_fpos_ff  <= fpos_ff;
         out_total_ff <= count_ff;
         out_rej_ff   <= rej_ff;
      end
   end

   assign req_chan.ready          = cmd.in_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_word      = out_word_ff;
   assign rsp_chan.found          = out_found_ff;
   assign rsp_chan.found_position = out_fpos_ff;
   assign rsp_chan.entry_total    = out_total_ff;
   assign rsp_chan.rejected       = out_rej_ff;

   assign status.in_valid         = req_chan.valid;
   assign status.op               = op_ff;
   assign status.pos_lt_count     = pos_ext < count_ff;
   assign status.over_cap         = {6'd0, newc} > CAP_LIMIT;
   assign status.idx_lt_pos       = idx_ff < pos_ext;
   assign status.idx_gt_pos       = idx_ff > pos_ext;
   assign status.idx_lt_count     = idx_ff < count_ff;
   assign status.idx_inc_lt_count = (idx_ff + 7'd1) < count_ff;
   assign status.match            = rd_data == value_ff;
   assign status.out_free         = !rsp_valid_ff || rsp_chan.ready;

endmodule

`default_nettype wire

/* rtl/ils_controller.sv */
// ils_controller: state machine that sequences fill, shift, search and
// result hand-off; depends on ils_pkg
`timescale 1ns / 1ps
`default_nettype none

module ils_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ils_pkg::ctl_status_type status,
   output      ils_pkg::ctl_cmd_type    cmd
);
   import ils_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_FILL,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_REM_RD,
      S_REM_WR,
      S_READ_CAP,
      S_FIND_RD,
      S_FIND_CMP,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (status.in_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (op_type'(status.op))
               OP_INSERT: begin
                  if (status.over_cap) begin
                     cmd.res_reject = 1'b1;
                     state_in       = S_DONE;
                  end else begin
                     cmd.idx_sel = IDX_COUNT;
                     state_in    = S_FILL;
                  end
               end
               OP_SET: begin
                  if (status.pos_lt_count) begin
                     cmd.mem_wr = 1'b1;
                     cmd.wa_sel = WA_POS;
                     cmd.wd_sel = WD_VALUE;
                     state_in   = S_DONE;
                  end else if (status.over_cap) begin
                     cmd.res_reject = 1'b1;
                     state_in       = S_DONE;
                  end else begin
                     cmd.idx_sel = IDX_COUNT;
                     state_in    = S_FILL;
                  end
               end
               OP_REMOVE: begin
                  if (status.pos_lt_count) begin
                     cmd.idx_sel = IDX_POS;
                     state_in    = S_REM_RD;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_READ: begin
                  if (status.pos_lt_count) begin
                     cmd.mem_rd = 1'b1;
                     cmd.rd_sel = RA_POS;
                     state_in   = S_READ_CAP;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_FIND: begin
                  cmd.idx_sel = IDX_ZERO;
                  state_in    = S_FIND_RD;
               end
               OP_CLEAR: begin
                  cmd.cnt_sel = CNT_ZERO;
                  state_in    = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         // zero the gap between the old end and the target position
         S_FILL: begin
            if (status.idx_lt_pos) begin
               cmd.mem_wr  = 1'b1;
               cmd.wa_sel  = WA_IDX;
               cmd.wd_sel  = WD_ZERO;
               cmd.idx_sel = IDX_INC;
            end else if (op_type'(status.op) == OP_INSERT) begin
               cmd.idx_sel = IDX_TOP;
               state_in    = S_SHIFT_RD;
            end else begin
               cmd.mem_wr  = 1'b1;
               cmd.wa_sel  = WA_POS;
               cmd.wd_sel  = WD_VALUE;
               cmd.cnt_sel = CNT_NEW;
               state_in    = S_DONE;
            end
         end
         // move entries up one place, top first
         S_SHIFT_RD: begin
            if (status.idx_gt_pos) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RA_IDX_DEC;
               state_in   = S_SHIFT_WR;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_SHIFT_WR: begin
            cmd.mem_wr  = 1'b1;
            cmd.wa_sel  = WA_IDX;
            cmd.wd_sel  = WD_RDATA;
            cmd.idx_sel = IDX_DEC;
            state_in    = S_SHIFT_RD;
         end
         S_PLACE: begin
            cmd.mem_wr  = 1'b1;
            cmd.wa_sel  = WA_POS;
            cmd.wd_sel  = WD_VALUE;
            cmd.cnt_sel = CNT_NEW;
            state_in    = S_DONE;
         end
         // move entries down one place, bottom first
         S_REM_RD: begin
            if (status.idx_inc_lt_count) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RA_IDX_INC;
               state_in   = S_REM_WR;
            end else begin
               cmd.cnt_sel = CNT_DEC;
               state_in    = S_DONE;
            end
         end
         S_REM_WR: begin
            cmd.mem_wr  = 1'b1;
            cmd.wa_sel  = WA_IDX;
            cmd.wd_sel  = WD_RDATA;
            cmd.idx_sel = IDX_INC;
            state_in    = S_REM_RD;
         end
         S_READ_CAP: begin
            cmd.res_read = 1'b1;
            state_in     = S_DONE;
         end
         S_FIND_RD: begin
            if (status.idx_lt_count) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RA_IDX;
               state_in   = S_FIND_CMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FIND_CMP: begin
            if (status.match) begin
               cmd.res_found = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.idx_sel = IDX_INC;
               state_in    = S_FIND_RD;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/indexed_list_store.sv */
// indexed_list_store: ordered list of 32-bit words in a single-port-per-side ram
// clear, in-place set and refused or out-of-range requests go straight to the result; read
// captures one ram word; set past the end zero-fills the gap first; insert zero-fills the
// gap, then shifts entries up one place; remove shifts entries down; find walks entries
// in order from the first and stops on the first match
// throughput: one request at a time, next one taken the cycle after the result is loaded;
// reset: synchronous, clears the entry count and the controller; ram content is kept
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_store (
   input  wire logic clock,
   input  wire logic reset,
   ils_req_if.sink   req_chan,
   ils_rsp_if.source rsp_chan
);
   import ils_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   ils_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   ils_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .status   (status)
   );

   // list length reported never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ({25'd0, rsp_chan.entry_total} <= 32'(CAPACITY)))
      else $error("entry_total beyond capacity");

   // a refused request reports no read word and no match
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.rejected) |->
      (!rsp_chan.found && (rsp_chan.read_word == '0)))
      else $error("rejected result carries data");

   // the ram never sees a read and a write in one cycle
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.mem_wr && cmd.mem_rd))
      else $error("ram read and write together");

   // after a transaction is taken the block stops accepting until it is done
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second request taken while busy");

endmodule

`default_nettype wire
